@@ design/pmi_pkg.sv @@
// Shared types and constants for the periodic minimum-image core.
// Holds field widths, register indexes, box shape codes and the configuration struct.
`timescale 1ns / 1ps
`default_nettype none

package pmi_pkg;

	localparam int FIELD_W              = 32;
	localparam int CFG_W                = 64;
	localparam int IDX_W                = 3;
	localparam int COORD_WIDTH_DEF      = 32;
	localparam int RECIP_FRAC_BITS_DEF  = 30;
	localparam int COORD_FRAC_BITS      = 16;
	localparam int N_LIMIT_EXP          = 29;

	typedef enum logic [1:0] {
		SHAPE_NULL  = 2'd0,
		SHAPE_ORTHO = 2'd1,
		SHAPE_MONO  = 2'd2,
		SHAPE_TRI   = 2'd3
	} box_shape_t;

	typedef enum logic [IDX_W-1:0] {
		REG_BOX_SHAPE   = 3'd0,
		REG_RECIP_XX_YY = 3'd1,
		REG_RECIP_ZZ_XY = 3'd2,
		REG_RECIP_XZ_YZ = 3'd3,
		REG_LEN_XX_YY   = 3'd4,
		REG_LEN_ZZ_XY   = 3'd5,
		REG_LEN_XZ_YZ   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		box_shape_t                 shape;
		logic signed [FIELD_W-1:0]  rxx;
		logic signed [FIELD_W-1:0]  ryy;
		logic signed [FIELD_W-1:0]  rzz;
		logic signed [FIELD_W-1:0]  rxy;
		logic signed [FIELD_W-1:0]  rxz;
		logic signed [FIELD_W-1:0]  ryz;
		logic signed [FIELD_W-1:0]  lxx;
		logic signed [FIELD_W-1:0]  lyy;
		logic signed [FIELD_W-1:0]  lzz;
		logic signed [FIELD_W-1:0]  lxy;
		logic signed [FIELD_W-1:0]  lxz;
		logic signed [FIELD_W-1:0]  lyz;
	} pmi_cfg_t;

endpackage

`default_nettype wire

@@ design/periodic_minimum_image_core.sv @@
// Periodic minimum-image core: folds one displacement per transaction into the configured box.
// Results are registered at each stage below; one transaction per cycle sustained unless out_stall holds.
// Stages: reciprocal products, rounding to image index, box vector products, subtract
// and saturate. Each stage holds its own valid bit and fills a bubble while downstream stalls.
// Reset clears all valid bits and all configuration registers to zero.
// Depends on pmi_pkg and pmi_regs.
`timescale 1ns / 1ps
`default_nettype none

module periodic_minimum_image_core #(
	parameter int COORD_WIDTH     = pmi_pkg::COORD_WIDTH_DEF,
	parameter int RECIP_FRAC_BITS = pmi_pkg::RECIP_FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                wr_en,
	input  wire logic [pmi_pkg::IDX_W-1:0]           wr_index,
	input  wire logic [pmi_pkg::CFG_W-1:0]           wr_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                func,
	input  wire logic signed [pmi_pkg::FIELD_W-1:0]  in_dx,
	input  wire logic signed [pmi_pkg::FIELD_W-1:0]  in_dy,
	input  wire logic signed [pmi_pkg::FIELD_W-1:0]  in_dz,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [pmi_pkg::FIELD_W-1:0]       out_dx,
	output logic signed [pmi_pkg::FIELD_W-1:0]       out_dy,
	output logic signed [pmi_pkg::FIELD_W-1:0]       out_dz
);

	localparam int FW    = pmi_pkg::FIELD_W;
	localparam int PW    = 2 * FW;
	localparam int SUM_W = PW + 2;
	localparam int K     = pmi_pkg::COORD_FRAC_BITS + RECIP_FRAC_BITS;
	localparam int N_W   = pmi_pkg::N_LIMIT_EXP + 2;
	localparam int QW    = N_W + FW;
	localparam int AW    = FW + 1;
	localparam int FDW   = FW + 2;
	localparam int TOP_W = SUM_W - COORD_WIDTH + 1;

	localparam logic signed [SUM_W-1:0] HALF  = {{(SUM_W-1){1'b0}}, 1'b1} << (K - 1);
	localparam logic signed [SUM_W-1:0] N_MAX = {{(SUM_W-1){1'b0}}, 1'b1} << pmi_pkg::N_LIMIT_EXP;
	localparam logic signed [SUM_W-1:0] N_MIN = -N_MAX;
	localparam logic signed [PW-1:0]    P_ZERO = '0;
	localparam logic signed [QW-1:0]    Q_ZERO = '0;

	typedef enum logic [1:0] {
		OP_PASS  = 2'd0,
		OP_FOLD  = 2'd1,
		OP_IMAGE = 2'd2
	} op_t;

	function automatic logic signed [N_W-1:0] clamp_n(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] c;
		c = v;
		if (v > N_MAX) c = N_MAX;
		if (v < N_MIN) c = N_MIN;
		return N_W'(c);
	endfunction

	function automatic logic signed [FW-1:0] sat_out(input logic signed [SUM_W-1:0] v);
		logic [TOP_W-1:0]              top;
		logic signed [COORD_WIDTH-1:0] s;
		top = v[SUM_W-1:COORD_WIDTH-1];
		if (&top || ~|top) begin
			s = COORD_WIDTH'(v);
		end else begin
			s = {v[SUM_W-1], {(COORD_WIDTH-1){~v[SUM_W-1]}}};
		end
		return FW'(s);
	endfunction

	function automatic logic signed [FDW-1:0] fold_abs(input logic signed [FW-1:0] d,
			input logic signed [FW-1:0] len);
		logic signed [AW-1:0]  a;
		logic signed [FDW-1:0] twice;
		logic signed [FDW-1:0] lx;
		a     = d[FW-1] ? -AW'(d) : AW'(d);
		twice = FDW'(a) <<< 1;
		lx    = FDW'(len);
		return (twice > lx) ? FDW'(a) - lx : FDW'(a);
	endfunction

	pmi_pkg::pmi_cfg_t cfg;

	pmi_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	assign rdy_s4   = !valid_s4 || !out_stall;
	assign rdy_s3   = !valid_s3 || rdy_s4;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= in_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
		end
	end

	// Stage 1: reciprocal products
	op_t                  op_in;
	logic                 mono_in, tri_in;
	op_t                  op_s1;
	logic                 mono_s1, tri_s1;
	logic signed [FW-1:0] x_s1, y_s1, z_s1;
	logic signed [PW-1:0] pxx_s1, pxy_s1, pxz_s1, pyy_s1, pyz_s1, pzz_s1;

	assign mono_in = (cfg.shape == pmi_pkg::SHAPE_MONO) || (cfg.shape == pmi_pkg::SHAPE_TRI);
	assign tri_in  = (cfg.shape == pmi_pkg::SHAPE_TRI);

	always_comb begin
		case (cfg.shape)
			pmi_pkg::SHAPE_NULL:  op_in = OP_PASS;
			pmi_pkg::SHAPE_ORTHO: op_in = func ? OP_FOLD : OP_IMAGE;
			default:              op_in = OP_IMAGE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			op_s1   <= op_in;
			mono_s1 <= mono_in;
			tri_s1  <= tri_in;
			x_s1    <= in_dx;
			y_s1    <= in_dy;
			z_s1    <= in_dz;
			pxx_s1  <= in_dx * cfg.rxx;
			pxy_s1  <= tri_in ? in_dy * cfg.rxy : P_ZERO;
			pxz_s1  <= mono_in ? in_dz * cfg.rxz : P_ZERO;
			pyy_s1  <= in_dy * cfg.ryy;
			pyz_s1  <= tri_in ? in_dz * cfg.ryz : P_ZERO;
			pzz_s1  <= in_dz * cfg.rzz;
		end
	end

	// Stage 2: round to the nearest image index and clamp
	op_t                   op_s2;
	logic                  mono_s2, tri_s2;
	logic signed [FW-1:0]  x_s2, y_s2, z_s2;
	logic signed [N_W-1:0] nx_s2, ny_s2, nz_s2;
	logic signed [SUM_W-1:0] fsum_x, fsum_y, fsum_z;

	assign fsum_x = SUM_W'(pxx_s1) + SUM_W'(pxy_s1) + SUM_W'(pxz_s1) + HALF;
	assign fsum_y = SUM_W'(pyy_s1) + SUM_W'(pyz_s1) + HALF;
	assign fsum_z = SUM_W'(pzz_s1) + HALF;

	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			op_s2   <= op_s1;
			mono_s2 <= mono_s1;
			tri_s2  <= tri_s1;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			z_s2    <= z_s1;
			nx_s2   <= clamp_n(fsum_x >>> K);
			ny_s2   <= clamp_n(fsum_y >>> K);
			nz_s2   <= clamp_n(fsum_z >>> K);
		end
	end

	// Stage 3: box vector products and magnitude fold
	op_t                   op_s3;
	logic signed [FW-1:0]  x_s3, y_s3, z_s3;
	logic signed [FDW-1:0] fx_s3, fy_s3, fz_s3;
	logic signed [QW-1:0]  qxx_s3, qxy_s3, qxz_s3, qyy_s3, qyz_s3, qzz_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3 && valid_s2) begin
			op_s3  <= op_s2;
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			z_s3   <= z_s2;
			fx_s3  <= fold_abs(x_s2, cfg.lxx);
			fy_s3  <= fold_abs(y_s2, cfg.lyy);
			fz_s3  <= fold_abs(z_s2, cfg.lzz);
			qxx_s3 <= nx_s2 * cfg.lxx;
			qxy_s3 <= tri_s2 ? ny_s2 * cfg.lxy : Q_ZERO;
			qxz_s3 <= mono_s2 ? nz_s2 * cfg.lxz : Q_ZERO;
			qyy_s3 <= ny_s2 * cfg.lyy;
			qyz_s3 <= tri_s2 ? nz_s2 * cfg.lyz : Q_ZERO;
			qzz_s3 <= nz_s2 * cfg.lzz;
		end
	end

	// Stage 4: subtract, select and saturate
	logic signed [SUM_W-1:0] vx, vy, vz;
	logic signed [FW-1:0]    dx_s4, dy_s4, dz_s4;

	always_comb begin
		case (op_s3)
			OP_PASS: begin
				vx = SUM_W'(x_s3);
				vy = SUM_W'(y_s3);
				vz = SUM_W'(z_s3);
			end
			OP_FOLD: begin
				vx = SUM_W'(fx_s3);
				vy = SUM_W'(fy_s3);
				vz = SUM_W'(fz_s3);
			end
			default: begin
				vx = SUM_W'(x_s3) - (SUM_W'(qxx_s3) + SUM_W'(qxy_s3) + SUM_W'(qxz_s3));
				vy = SUM_W'(y_s3) - (SUM_W'(qyy_s3) + SUM_W'(qyz_s3));
				vz = SUM_W'(z_s3) - SUM_W'(qzz_s3);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && valid_s3) begin
			dx_s4 <= sat_out(vx);
			dy_s4 <= sat_out(vy);
			dz_s4 <= sat_out(vz);
		end
	end

	assign out_valid = valid_s4;
	assign out_dx    = dx_s4;
	assign out_dy    = dy_s4;
	assign out_dz    = dz_s4;

endmodule

`default_nettype wire

@@ design/pmi_regs.sv @@
// Configuration register file for the periodic minimum-image core.
// Decodes indexed writes into the box shape, reciprocal and box vector entries; uses pmi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmi_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [pmi_pkg::IDX_W-1:0]     wr_index,
	input  wire logic [pmi_pkg::CFG_W-1:0]     wr_data,
	output pmi_pkg::pmi_cfg_t                  cfg
);

	localparam int FW = pmi_pkg::FIELD_W;

	pmi_pkg::pmi_cfg_t   cfg_q;
	logic signed [FW-1:0] hi_half;
	logic signed [FW-1:0] lo_half;

	assign hi_half = wr_data[2*FW-1:FW];
	assign lo_half = wr_data[FW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (pmi_pkg::cfg_reg_t'(wr_index))
				pmi_pkg::REG_BOX_SHAPE: begin
					cfg_q.shape <= pmi_pkg::box_shape_t'(wr_data[1:0]);
				end
				pmi_pkg::REG_RECIP_XX_YY: begin
					cfg_q.rxx <= hi_half;
					cfg_q.ryy <= lo_half;
				end
				pmi_pkg::REG_RECIP_ZZ_XY: begin
					cfg_q.rzz <= hi_half;
					cfg_q.rxy <= lo_half;
				end
				pmi_pkg::REG_RECIP_XZ_YZ: begin
					cfg_q.rxz <= hi_half;
					cfg_q.ryz <= lo_half;
				end
				pmi_pkg::REG_LEN_XX_YY: begin
					cfg_q.lxx <= hi_half;
					cfg_q.lyy <= lo_half;
				end
				pmi_pkg::REG_LEN_ZZ_XY: begin
					cfg_q.lzz <= hi_half;
					cfg_q.lxy <= lo_half;
				end
				pmi_pkg::REG_LEN_XZ_YZ: begin
					cfg_q.lxz <= hi_half;
					cfg_q.lyz <= lo_half;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ tb/periodic_minimum_image_checker.sv @@
// Checker for periodic_minimum_image_core: mirrors the register writes and predicts each folded
// displacement, then compares every output transaction with the oldest prediction.
// Depends on pmi_pkg.
`timescale 1ns / 1ps

module periodic_minimum_image_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [pmi_pkg::IDX_W-1:0]           wr_index,
	input  logic [pmi_pkg::CFG_W-1:0]           wr_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic                                func,
	input  logic signed [pmi_pkg::FIELD_W-1:0]  in_dx,
	input  logic signed [pmi_pkg::FIELD_W-1:0]  in_dy,
	input  logic signed [pmi_pkg::FIELD_W-1:0]  in_dz,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [pmi_pkg::FIELD_W-1:0]  out_dx,
	input  logic signed [pmi_pkg::FIELD_W-1:0]  out_dy,
	input  logic signed [pmi_pkg::FIELD_W-1:0]  out_dz,
	output int                                  faults,
	output int                                  backlog
);
	import pmi_pkg::*;

	typedef logic signed [79:0] wide_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] dx;
		logic signed [FIELD_W-1:0] dy;
		logic signed [FIELD_W-1:0] dz;
	} image_t;

	localparam int    FRAC_SUM  = COORD_FRAC_BITS + RECIP_FRAC_BITS_DEF;
	localparam wide_t ONE       = 1;
	localparam wide_t HALF_UNIT = ONE <<< (FRAC_SUM - 1);
	localparam wide_t INDEX_MAX = ONE <<< N_LIMIT_EXP;
	localparam wide_t COORD_MAX = (ONE <<< (COORD_WIDTH_DEF - 1)) - 1;
	localparam wide_t COORD_MIN = -COORD_MAX - 1;

	box_shape_t shape;
	wide_t      rxx, ryy, rzz, rxy, rxz, ryz;
	wide_t      lxx, lyy, lzz, lxy, lxz, lyz;
	image_t     images_due[$];

	// floor(sum / 2^FRAC_SUM + 1/2), held to the index range
	function automatic wide_t image_index(input wide_t frac_sum);
		wide_t n;
		n = (frac_sum + HALF_UNIT) >>> FRAC_SUM;
		if (n > INDEX_MAX)
			n = INDEX_MAX;
		if (n < -INDEX_MAX)
			n = -INDEX_MAX;
		return n;
	endfunction

	function automatic logic signed [FIELD_W-1:0] clamp_coord(input wide_t v);
		wide_t c;
		c = (v > COORD_MAX) ? COORD_MAX : ((v < COORD_MIN) ? COORD_MIN : v);
		return c[FIELD_W-1:0];
	endfunction

	function automatic wide_t fold_magnitude(input wide_t d, input wide_t len);
		wide_t a;
		a = (d < 0) ? -d : d;
		return (2 * a > len) ? a - len : a;
	endfunction

	function automatic image_t fold_displacement(input logic magnitude_only,
			input logic signed [FIELD_W-1:0] dx, dy, dz);
		wide_t  x, y, z, nx, ny, nz, rx, ry, rz;
		logic   is_mono, is_tri;
		image_t img;
		x = dx;
		y = dy;
		z = dz;
		rx = x;
		ry = y;
		rz = z;
		is_mono = (shape == SHAPE_MONO) || (shape == SHAPE_TRI);
		is_tri = shape == SHAPE_TRI;
		if (shape == SHAPE_ORTHO && magnitude_only) begin
			rx = fold_magnitude(x, lxx);
			ry = fold_magnitude(y, lyy);
			rz = fold_magnitude(z, lzz);
		end else if (shape != SHAPE_NULL) begin
			nx = image_index(x * rxx + (is_tri ? y * rxy : 0) + (is_mono ? z * rxz : 0));
			ny = image_index(y * ryy + (is_tri ? z * ryz : 0));
			nz = image_index(z * rzz);
			rx = x - (nx * lxx + (is_tri ? ny * lxy : 0) + (is_mono ? nz * lxz : 0));
			ry = y - (ny * lyy + (is_tri ? nz * lyz : 0));
			rz = z - nz * lzz;
		end
		img.dx = clamp_coord(rx);
		img.dy = clamp_coord(ry);
		img.dz = clamp_coord(rz);
		return img;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		image_t want;
		image_t seen;
		if (!arst_n) begin
			shape = SHAPE_NULL;
			rxx = 0; ryy = 0; rzz = 0; rxy = 0; rxz = 0; ryz = 0;
			lxx = 0; lyy = 0; lzz = 0; lxy = 0; lxz = 0; lyz = 0;
			images_due.delete();
			faults = 0;
			backlog <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen = {out_dx, out_dy, out_dz};
				if (images_due.size() == 0) begin
					if (faults < 10)
						$display("unexpected transaction: %0d %0d %0d", seen.dx, seen.dy,
							seen.dz);
					faults++;
				end else begin
					want = images_due.pop_front();
					if (seen.dx !== want.dx || seen.dy !== want.dy || seen.dz !== want.dz) begin
						if (faults < 10)
							$display("image mismatch: expected %0d %0d %0d, got %0d %0d %0d",
								want.dx, want.dy, want.dz, seen.dx, seen.dy, seen.dz);
						faults++;
					end
				end
			end
			if (in_valid && !in_stall)
				images_due.push_back(fold_displacement(func, in_dx, in_dy, in_dz));
			if (wr_en) begin
				case (wr_index)
					REG_BOX_SHAPE: shape = box_shape_t'(wr_data[1:0]);
					REG_RECIP_XX_YY: begin
						rxx = $signed(wr_data[63:32]);
						ryy = $signed(wr_data[31:0]);
					end
					REG_RECIP_ZZ_XY: begin
						rzz = $signed(wr_data[63:32]);
						rxy = $signed(wr_data[31:0]);
					end
					REG_RECIP_XZ_YZ: begin
						rxz = $signed(wr_data[63:32]);
						ryz = $signed(wr_data[31:0]);
					end
					REG_LEN_XX_YY: begin
						lxx = $signed(wr_data[63:32]);
						lyy = $signed(wr_data[31:0]);
					end
					REG_LEN_ZZ_XY: begin
						lzz = $signed(wr_data[63:32]);
						lxy = $signed(wr_data[31:0]);
					end
					REG_LEN_XZ_YZ: begin
						lxz = $signed(wr_data[63:32]);
						lyz = $signed(wr_data[31:0]);
					end
					default: ;
				endcase
			end
			backlog <= images_due.size();
		end
	end

endmodule

@@ tb/periodic_minimum_image_core_test.sv @@
// Top of the periodic_minimum_image_core testbench: clock, reset, register loads and
// displacement traffic under varying back-pressure; the verdict comes from the checker count.
// Depends on pmi_pkg, periodic_minimum_image_core and periodic_minimum_image_checker.
`timescale 1ns / 1ps

module periodic_minimum_image_core_test;
	import pmi_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_PHASES = 9;
	localparam int PHASE_ITEMS   = 84;
	localparam int HOLD_CYCLES   = 64;
	localparam int SETTLE_CYCLES = 8;

	localparam logic [IDX_W-1:0]          REG_UNMAPPED = 3'd7;
	localparam logic signed [FIELD_W-1:0] CMAX         = 32'sh7FFF_FFFF;
	localparam logic signed [FIELD_W-1:0] CMIN         = 32'sh8000_0000;
	localparam logic signed [FIELD_W-1:0] CELL         = 32'sh0008_0000;
	localparam logic signed [FIELD_W-1:0] HALF_CELL    = 32'sh0004_0000;
	localparam logic signed [FIELD_W-1:0] RECIP_CELL   = 32'sh0800_0000;
	localparam real                       RECIP_SCALE  = 70368744177664.0;

	logic                       clk;
	logic                       arst_n    = 1'b0;
	logic                       wr_en     = 1'b0;
	logic [IDX_W-1:0]           wr_index  = '0;
	logic [CFG_W-1:0]           wr_data   = '0;
	logic                       in_valid  = 1'b0;
	logic                       in_stall;
	logic                       func      = 1'b0;
	logic signed [FIELD_W-1:0]  in_dx     = '0;
	logic signed [FIELD_W-1:0]  in_dy     = '0;
	logic signed [FIELD_W-1:0]  in_dz     = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [FIELD_W-1:0]  out_dx;
	logic signed [FIELD_W-1:0]  out_dy;
	logic signed [FIELD_W-1:0]  out_dz;

	int                         faults;
	int                         backlog;
	int                         send_idle = 15;
	int                         recv_idle = 68;
	bit                         hold_req  = 1'b0;
	logic signed [FIELD_W-1:0]  half_x    = '0;
	logic signed [FIELD_W-1:0]  half_y    = '0;
	logic signed [FIELD_W-1:0]  half_z    = '0;

	periodic_minimum_image_core DUT (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .func(func),
		.in_dx(in_dx), .in_dy(in_dy), .in_dz(in_dz),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_dx(out_dx), .out_dy(out_dy), .out_dz(out_dz)
	);

	periodic_minimum_image_checker fold_check (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .func(func),
		.in_dx(in_dx), .in_dy(in_dy), .in_dz(in_dz),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_dx(out_dx), .out_dy(out_dy), .out_dz(out_dz),
		.faults(faults), .backlog(backlog)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("periodic_minimum_image_core_test: errors");
		$finish;
	end

	// hold off for a long stretch on request, otherwise stall at random
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	task automatic offer(input logic fn, input logic signed [FIELD_W-1:0] x, y, z);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		in_dx <= x;
		in_dy <= y;
		in_dz <= z;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (backlog != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
	endtask

	task automatic load_box(input logic [CFG_W-1:0] shape_word, recip_a, recip_b, recip_c,
			len_a, len_b, len_c);
		write_reg(REG_BOX_SHAPE, shape_word);
		write_reg(REG_RECIP_XX_YY, recip_a);
		write_reg(REG_RECIP_ZZ_XY, recip_b);
		write_reg(REG_RECIP_XZ_YZ, recip_c);
		write_reg(REG_LEN_XX_YY, len_a);
		write_reg(REG_LEN_ZZ_XY, len_b);
		write_reg(REG_LEN_XZ_YZ, len_c);
		wr_en <= 1'b0;
		half_x = $signed(len_a[63:32]) >>> 1;
		half_y = $signed(len_a[31:0]) >>> 1;
		half_z = $signed(len_b[63:32]) >>> 1;
	endtask

	// random tilted cell with its matching upper-triangular inverse
	task automatic load_lattice(input box_shape_t kind);
		int                        a, b, c, xy, xz, yz;
		real                       fa, fb, fc, fxy, fxz, fyz;
		logic signed [FIELD_W-1:0] qxx, qyy, qzz, qxy, qxz, qyz;
		a = $urandom_range(40 << 16, 1 << 17);
		b = $urandom_range(40 << 16, 1 << 17);
		c = $urandom_range(40 << 16, 1 << 17);
		xy = int'($urandom_range(a)) - a / 2;
		xz = int'($urandom_range(a)) - a / 2;
		yz = int'($urandom_range(b)) - b / 2;
		fa = a;
		fb = b;
		fc = c;
		fxy = xy;
		fxz = xz;
		fyz = yz;
		qxx = $rtoi(RECIP_SCALE / fa);
		qyy = $rtoi(RECIP_SCALE / fb);
		qzz = $rtoi(RECIP_SCALE / fc);
		qxy = $rtoi(-fxy * RECIP_SCALE / (fa * fb));
		qyz = $rtoi(-fyz * RECIP_SCALE / (fb * fc));
		qxz = $rtoi((fxy * fyz - fxz * fb) * RECIP_SCALE / (fa * fb * fc));
		load_box(64'(kind), {qxx, qyy}, {qzz, qxy}, {qxz, qyz}, {a, b}, {c, xy}, {xz, yz});
	endtask

	function automatic logic signed [FIELD_W-1:0] scatter(input logic signed [FIELD_W-1:0] half);
		longint      span, w;
		int unsigned pick;
		span = (half < 0) ? -longint'(half) : longint'(half);
		if (span == 0)
			span = 1 << 16;
		pick = $urandom_range(99);
		if (pick < 60)
			w = longint'($urandom) % (8 * span + 1) - 4 * span;
		else if (pick < 85)
			w = (2 * longint'($urandom_range(3)) + 1) * span + longint'($urandom_range(4)) - 2;
		else
			w = longint'($urandom);
		if ($urandom_range(1))
			w = -w;
		return w[FIELD_W-1:0];
	endfunction

	initial begin : stimulus
		box_shape_t kind;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(1'b0, CMAX, CMIN, 32'sd0);
		offer(1'b1, CMIN, -32'sd1, CMAX);
		offer(1'b0, -32'sd1, 32'sd1, 32'sd1);
		offer(1'b1, 32'sd0, 32'sd0, 32'sd0);
		drain();

		// ties at half a cell, with junk above the shape bits
		write_reg(REG_UNMAPPED, '1);
		load_box(64'hFFFF_FFFF_FFFF_FFFD, {RECIP_CELL, RECIP_CELL},
			{RECIP_CELL, 32'shFE00_0000}, {32'sh0100_0000, 32'shFF00_0000},
			{CELL, CELL}, {CELL, 32'sh0002_0000}, {32'shFFFE_0000, 32'sh0001_0000});
		offer(1'b0, HALF_CELL, -HALF_CELL, 3 * HALF_CELL);
		offer(1'b1, HALF_CELL, -HALF_CELL, -3 * HALF_CELL);
		offer(1'b0, HALF_CELL - 1, -HALF_CELL - 1, 32'sd0);
		offer(1'b1, HALF_CELL + 1, -HALF_CELL + 1, 32'sd0);
		offer(1'b0, CMAX, CMIN, -32'sd1);
		offer(1'b1, CMAX, CMIN, -32'sd1);
		offer(1'b1, CMIN, CMAX, 32'sd1);
		drain();
		write_reg(REG_BOX_SHAPE, 64'(SHAPE_MONO));
		wr_en <= 1'b0;
		offer(1'b0, 3 * HALF_CELL + 5, -HALF_CELL, HALF_CELL);
		offer(1'b1, -CELL, CELL, -3 * HALF_CELL);
		drain();
		write_reg(REG_BOX_SHAPE, 64'(SHAPE_TRI));
		wr_en <= 1'b0;
		offer(1'b0, HALF_CELL, 3 * HALF_CELL, -5 * HALF_CELL);
		offer(1'b1, CMIN, CMAX, CMIN);
		drain();

		// extreme and degenerate entries drive the outputs into saturation
		load_box(64'(SHAPE_TRI), {CMAX, CMIN}, {CMIN, CMAX}, {CMAX, CMIN},
			{CMIN, CMAX}, {CMAX, CMIN}, {32'sd0, CMAX});
		offer(1'b0, CMAX, CMAX, CMAX);
		offer(1'b0, CMIN, CMIN, CMIN);
		offer(1'b1, CMAX, CMIN, CMAX);
		offer(1'b0, 32'sd1, -32'sd1, 32'sd1);
		drain();
		write_reg(REG_BOX_SHAPE, 64'(SHAPE_ORTHO));
		wr_en <= 1'b0;
		offer(1'b1, CMIN, CMAX, -32'sd1);
		offer(1'b0, CMAX, CMIN, 32'sd1);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			case (p / 3)
				0: begin
					send_idle = 15;
					recv_idle = 68;
				end
				1: begin
					send_idle = 68;
					recv_idle = 15;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			kind = box_shape_t'((p + 1) % 4);
			if (p % 3 == 2)
				load_box(64'(kind), {$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom});
			else
				load_lattice(kind);
			if (p == RANDOM_PHASES - 3)
				hold_req = 1'b1;
			repeat (PHASE_ITEMS)
				offer(1'($urandom_range(1)), scatter(half_x), scatter(half_y),
					scatter(half_z));
		end
		drain();

		if (faults == 0)
			$display("periodic_minimum_image_core_test: clean");
		else
			$display("periodic_minimum_image_core_test: errors");
		$finish;
	end

endmodule
